[hdl/wgo_pkg.sv]
// Shared widths, constants, register indexes and the CORDIC angle table for the odometry core.
package wgo_pkg;

    localparam int COUNT_W = 16;
    localparam int ANGLE_W = 16;
    localparam int DELTA_W = 17;
    localparam int SUM_W   = 18;
    localparam int MPP_W   = 28;
    localparam int WARM_W  = 16;
    localparam int DIST_W  = 26;
    localparam int POS_W   = 48;
    localparam int TRIG_W  = 32;
    localparam int INC_W   = 28;

    localparam int DIST_PROD_W = DELTA_W + MPP_W;
    localparam int XY_PROD_W   = DIST_W + TRIG_W - 1;
    localparam int DIST_FRAC   = 17;
    localparam int TRIG_FRAC   = 30;

    localparam int S_TDATA_W = 48;
    localparam int M_TDATA_W = 192;
    localparam int CFG_IDX_W = 8;
    localparam int CFG_DATA_W = MPP_W;

    localparam logic [CFG_IDX_W-1:0] REG_METRES_PER_PULSE = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WARMUP_TICKS     = 8'd1;

    localparam logic [MPP_W-1:0]  MPP_RESET    = 28'd9850078;
    localparam logic [WARM_W-1:0] WARMUP_RESET = 16'd200;

    localparam logic [COUNT_W-1:0] QUARTER_COUNT       = 16'd16384;
    localparam logic [COUNT_W-1:0] THREE_QUARTER_COUNT = 16'd49152;
    localparam logic [DELTA_W-1:0] FULL_COUNT          = 17'h10000;

    localparam logic [DIST_W-1:0] DIST_POS_LIMIT = 26'h1FFFFFF;
    localparam logic [DIST_W-1:0] DIST_NEG_LIMIT = 26'h2000000;

    localparam logic signed [POS_W-1:0] POS_MAX = {1'b0, {(POS_W-1){1'b1}}};
    localparam logic signed [POS_W-1:0] POS_MIN = {1'b1, {(POS_W-1){1'b0}}};

    localparam logic [ANGLE_W-1:0] EIGHTH_TURN = 16'd8192;
    localparam logic [TRIG_W-1:0]  CORDIC_START = 32'd652032874;

    localparam int ATAN_DEPTH = 24;
    localparam int ATAN_IDX_W = $clog2(ATAN_DEPTH);

    // atan(2^-i) in units of 2^-32 turn
    function automatic logic [TRIG_W-1:0] atan_turn(input logic [ATAN_IDX_W-1:0] idx);
        case (idx)
            5'd0:    atan_turn = 32'd536870912;
            5'd1:    atan_turn = 32'd316933406;
            5'd2:    atan_turn = 32'd167458907;
            5'd3:    atan_turn = 32'd85004756;
            5'd4:    atan_turn = 32'd42667331;
            5'd5:    atan_turn = 32'd21354465;
            5'd6:    atan_turn = 32'd10679838;
            5'd7:    atan_turn = 32'd5340245;
            5'd8:    atan_turn = 32'd2670163;
            5'd9:    atan_turn = 32'd1335087;
            5'd10:   atan_turn = 32'd667544;
            5'd11:   atan_turn = 32'd333772;
            5'd12:   atan_turn = 32'd166886;
            5'd13:   atan_turn = 32'd83443;
            5'd14:   atan_turn = 32'd41722;
            5'd15:   atan_turn = 32'd20861;
            5'd16:   atan_turn = 32'd10430;
            5'd17:   atan_turn = 32'd5215;
            5'd18:   atan_turn = 32'd2608;
            5'd19:   atan_turn = 32'd1304;
            5'd20:   atan_turn = 32'd652;
            5'd21:   atan_turn = 32'd326;
            5'd22:   atan_turn = 32'd163;
            5'd23:   atan_turn = 32'd81;
            default: atan_turn = '0;
        endcase
    endfunction

endpackage

[hdl/wheel_gyro_odometry_core.sv]
// Top level of the wheel and gyro odometry core: sequencer, state and stream ports.
//
// Input stream (s_axis): one transfer per odometry tick with the raw left and right
// encoder counts and the gyro binary angle. Output stream (m_axis): one pose transfer
// per tick once warm-up is over. Configuration channel (cfg_*): always ready; write
// only while the core is idle. Index 0 sets metres per pulse, index 1 the warm-up
// tick count; other indexes are ignored.
// A warm-up tick is handled in idle and gives no output. A normal tick runs the 28
// steps of the bit-serial distance multiplier (the CORDIC runs alongside it), a
// distance register step, a wait for the CORDIC, the 31 steps of the two bit-serial
// position multipliers working in parallel, then a rounding step and the final
// accumulate step that presents the output. The next tick is taken only once the
// sequencer is back in idle, so the core takes no new tick while one is in progress.
// Reset clears the position, heading, previous inputs and warm-up count and loads the
// register defaults. The result sits in an output register; while the receiver
// stalls, the core still takes the next tick and runs it, holding the new pose in the
// final step until the pending transfer completes.
module wheel_gyro_odometry_core #(
    parameter int TRIG_ITERATIONS = 16
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // left_count, right_count, gyro_angle
    input  logic [wgo_pkg::S_TDATA_W-1:0]      s_axis_tdata,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // pos_x, pos_y, heading, heading_step, step_distance, left_delta, right_delta, pad
    output logic [wgo_pkg::M_TDATA_W-1:0]      m_axis_tdata,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [wgo_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [wgo_pkg::CFG_DATA_W-1:0]     cfg_data
);

    import wgo_pkg::*;

    localparam logic [DIST_PROD_W-1:0] DIST_HALF = DIST_PROD_W'(1) << (DIST_FRAC - 1);
    localparam logic [XY_PROD_W-1:0]   XY_HALF   = XY_PROD_W'(1) << (TRIG_FRAC - 1);
    localparam int DMAG_W = DIST_PROD_W - DIST_FRAC;
    localparam int IMAG_W = XY_PROD_W - TRIG_FRAC;
    localparam int PAD_W  = M_TDATA_W - 2 * POS_W - 2 * ANGLE_W - DIST_W - 2 * DELTA_W;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL_D,
        ST_DIST,
        ST_TRIG,
        ST_MUL_XY,
        ST_ROUND,
        ST_ACC
    } state_t;

    function automatic logic [DELTA_W-1:0] unwrap(input logic [COUNT_W-1:0] cur,
                                                  input logic [COUNT_W-1:0] prev);
        logic [DELTA_W-1:0] diff;
        diff = {1'b0, cur} - {1'b0, prev};
        if (cur < QUARTER_COUNT && prev > THREE_QUARTER_COUNT)
        begin
            unwrap = diff + FULL_COUNT;
        end
        else if (cur > THREE_QUARTER_COUNT && prev < QUARTER_COUNT)
        begin
            unwrap = diff - FULL_COUNT;
        end
        else
        begin
            unwrap = diff;
        end
    endfunction

    function automatic logic [POS_W-1:0] pos_sat(input logic [POS_W:0] s);
        if (s[POS_W] != s[POS_W-1])
        begin
            pos_sat = s[POS_W] ? POS_MIN : POS_MAX;
        end
        else
        begin
            pos_sat = s[POS_W-1:0];
        end
    endfunction

    state_t              state_reg;
    logic                out_valid_reg;
    logic [M_TDATA_W-1:0] tdata_reg;
    logic [MPP_W-1:0]    mpp_reg;
    logic [WARM_W-1:0]   warmup_ticks_reg;
    logic [WARM_W-1:0]   warmup_left_reg;
    logic [COUNT_W-1:0]  prev_left_reg;
    logic [COUNT_W-1:0]  prev_right_reg;
    logic [ANGLE_W-1:0]  prev_gyro_reg;
    logic [ANGLE_W-1:0]  heading_acc_reg;
    logic [POS_W-1:0]    x_acc_reg;
    logic [POS_W-1:0]    y_acc_reg;
    logic [DELTA_W-1:0]  left_delta_reg;
    logic [DELTA_W-1:0]  right_delta_reg;
    logic [ANGLE_W-1:0]  heading_step_reg;
    logic                sum_neg_reg;
    logic [DIST_W-1:0]   dist_reg;
    logic [DIST_W-1:0]   dist_abs_reg;
    logic                neg_x_reg;
    logic                neg_y_reg;
    logic [INC_W-1:0]    inc_x_reg;
    logic [INC_W-1:0]    inc_y_reg;

    logic [COUNT_W-1:0]  cur_left;
    logic [COUNT_W-1:0]  cur_right;
    logic [ANGLE_W-1:0]  cur_gyro;
    logic                in_xfer;
    logic                in_warmup;
    logic                tick_start;
    logic [DELTA_W-1:0]  left_delta;
    logic [DELTA_W-1:0]  right_delta;
    logic [SUM_W-1:0]    delta_sum;
    logic [SUM_W-1:0]    delta_sum_abs;
    logic [ANGLE_W-1:0]  gyro_step;
    logic [ANGLE_W-1:0]  heading_next;

    logic                  dmul_busy;
    logic [DIST_PROD_W-1:0] dist_prod;
    logic [DIST_PROD_W-1:0] dist_rounded;
    logic [DMAG_W-1:0]     dist_mag;
    logic [DIST_W-1:0]     dist_abs_next;
    logic [DIST_W-1:0]     dist_next;

    logic                  trig_busy;
    logic signed [TRIG_W-1:0] cos_val;
    logic signed [TRIG_W-1:0] sin_val;
    logic [TRIG_W-1:0]     cos_abs;
    logic [TRIG_W-1:0]     sin_abs;
    logic                  xy_start;

    logic                  xmul_busy;
    logic                  ymul_busy;
    logic [XY_PROD_W-1:0]  x_prod;
    logic [XY_PROD_W-1:0]  y_prod;
    logic [XY_PROD_W-1:0]  x_rounded;
    logic [XY_PROD_W-1:0]  y_rounded;
    logic [INC_W-1:0]      x_inc_mag;
    logic [INC_W-1:0]      y_inc_mag;

    logic [POS_W:0]        x_sum;
    logic [POS_W:0]        y_sum;
    logic [POS_W-1:0]      x_acc_next;
    logic [POS_W-1:0]      y_acc_next;
    logic                  out_free;

    always_comb
    begin
        cur_left   = s_axis_tdata[COUNT_W-1:0];
        cur_right  = s_axis_tdata[2*COUNT_W-1:COUNT_W];
        cur_gyro   = s_axis_tdata[2*COUNT_W+ANGLE_W-1:2*COUNT_W];
        in_xfer    = s_axis_tvalid && s_axis_tready;
        in_warmup  = warmup_left_reg < warmup_ticks_reg;
        tick_start = in_xfer && !in_warmup;

        left_delta    = unwrap(cur_left, prev_left_reg);
        right_delta   = unwrap(cur_right, prev_right_reg);
        delta_sum     = {left_delta[DELTA_W-1], left_delta}
                      + {right_delta[DELTA_W-1], right_delta};
        delta_sum_abs = delta_sum[SUM_W-1] ? -delta_sum : delta_sum;
        gyro_step     = cur_gyro - prev_gyro_reg;
        heading_next  = heading_acc_reg + gyro_step;

        // round half away from zero on the magnitude, then clamp to 26 bits
        dist_rounded = dist_prod + DIST_HALF;
        dist_mag     = dist_rounded[DIST_PROD_W-1:DIST_FRAC];
        if (sum_neg_reg)
        begin
            dist_abs_next = (dist_mag > DMAG_W'(DIST_NEG_LIMIT)) ? DIST_NEG_LIMIT
                                                                 : dist_mag[DIST_W-1:0];
        end
        else
        begin
            dist_abs_next = (dist_mag > DMAG_W'(DIST_POS_LIMIT)) ? DIST_POS_LIMIT
                                                                 : dist_mag[DIST_W-1:0];
        end
        dist_next = sum_neg_reg ? -dist_abs_next : dist_abs_next;

        cos_abs  = cos_val[TRIG_W-1] ? -cos_val : cos_val;
        sin_abs  = sin_val[TRIG_W-1] ? -sin_val : sin_val;
        xy_start = (state_reg == ST_TRIG) && !trig_busy;

        x_rounded = x_prod + XY_HALF;
        y_rounded = y_prod + XY_HALF;
        x_inc_mag = {{(INC_W-IMAG_W){1'b0}}, x_rounded[XY_PROD_W-1:TRIG_FRAC]};
        y_inc_mag = {{(INC_W-IMAG_W){1'b0}}, y_rounded[XY_PROD_W-1:TRIG_FRAC]};

        x_sum = {x_acc_reg[POS_W-1], x_acc_reg}
              + {{(POS_W+1-INC_W){inc_x_reg[INC_W-1]}}, inc_x_reg};
        y_sum = {y_acc_reg[POS_W-1], y_acc_reg}
              + {{(POS_W+1-INC_W){inc_y_reg[INC_W-1]}}, inc_y_reg};
        x_acc_next = pos_sat(x_sum);
        y_acc_next = pos_sat(y_sum);

        out_free = !out_valid_reg || m_axis_tready;
    end

    wgo_serial_mul #(
        .A_W (DELTA_W),
        .B_W (MPP_W)
    ) u_dist_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (tick_start),
        .a       (delta_sum_abs[DELTA_W-1:0]),
        .b       (mpp_reg),
        .busy    (dmul_busy),
        .product (dist_prod)
    );

    wgo_cordic #(
        .ITERATIONS (TRIG_ITERATIONS)
    ) u_cordic (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (tick_start),
        .angle   (heading_next),
        .busy    (trig_busy),
        .cos_out (cos_val),
        .sin_out (sin_val)
    );

    wgo_serial_mul #(
        .A_W (DIST_W),
        .B_W (TRIG_W - 1)
    ) u_x_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (xy_start),
        .a       (dist_abs_reg),
        .b       (cos_abs[TRIG_W-2:0]),
        .busy    (xmul_busy),
        .product (x_prod)
    );

    wgo_serial_mul #(
        .A_W (DIST_W),
        .B_W (TRIG_W - 1)
    ) u_y_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (xy_start),
        .a       (dist_abs_reg),
        .b       (sin_abs[TRIG_W-2:0]),
        .busy    (ymul_busy),
        .product (y_prod)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            out_valid_reg    <= 1'b0;
            mpp_reg          <= MPP_RESET;
            warmup_ticks_reg <= WARMUP_RESET;
            warmup_left_reg  <= '0;
            prev_left_reg    <= '0;
            prev_right_reg   <= '0;
            prev_gyro_reg    <= '0;
            heading_acc_reg  <= '0;
            x_acc_reg        <= '0;
            y_acc_reg        <= '0;
        end
        else
        begin
            if (cfg_valid)
            begin
                case (cfg_index)
                    REG_METRES_PER_PULSE: mpp_reg <= cfg_data;
                    REG_WARMUP_TICKS:     warmup_ticks_reg <= cfg_data[WARM_W-1:0];
                    default:
                    begin
                    end
                endcase
            end

            // in the final step a ready receiver always gets the new pose
            if (m_axis_tready && state_reg != ST_ACC)
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                ST_IDLE:
                begin
                    if (in_xfer)
                    begin
                        prev_left_reg  <= cur_left;
                        prev_right_reg <= cur_right;
                        prev_gyro_reg  <= cur_gyro;
                        if (in_warmup)
                        begin
                            warmup_left_reg <= warmup_left_reg + 1'b1;
                        end
                        else
                        begin
                            heading_acc_reg <= heading_next;
                            state_reg       <= ST_MUL_D;
                        end
                    end
                end
                ST_MUL_D:
                begin
                    if (!dmul_busy)
                    begin
                        state_reg <= ST_DIST;
                    end
                end
                ST_DIST:
                begin
                    state_reg <= ST_TRIG;
                end
                ST_TRIG:
                begin
                    if (!trig_busy)
                    begin
                        state_reg <= ST_MUL_XY;
                    end
                end
                ST_MUL_XY:
                begin
                    if (!xmul_busy && !ymul_busy)
                    begin
                        state_reg <= ST_ROUND;
                    end
                end
                ST_ROUND:
                begin
                    state_reg <= ST_ACC;
                end
                ST_ACC:
                begin
                    if (out_free)
                    begin
                        x_acc_reg     <= x_acc_next;
                        y_acc_reg     <= y_acc_next;
                        out_valid_reg <= 1'b1;
                        state_reg     <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                if (tick_start)
                begin
                    left_delta_reg   <= left_delta;
                    right_delta_reg  <= right_delta;
                    heading_step_reg <= gyro_step;
                    sum_neg_reg      <= delta_sum[SUM_W-1];
                end
            end
            ST_DIST:
            begin
                dist_reg     <= dist_next;
                dist_abs_reg <= dist_abs_next;
            end
            ST_TRIG:
            begin
                neg_x_reg <= sum_neg_reg ^ cos_val[TRIG_W-1];
                neg_y_reg <= sum_neg_reg ^ sin_val[TRIG_W-1];
            end
            ST_ROUND:
            begin
                inc_x_reg <= neg_x_reg ? -x_inc_mag : x_inc_mag;
                inc_y_reg <= neg_y_reg ? -y_inc_mag : y_inc_mag;
            end
            ST_ACC:
            begin
                if (out_free)
                begin
                    tdata_reg <= {{PAD_W{1'b0}}, right_delta_reg, left_delta_reg, dist_reg,
                                  heading_step_reg, heading_acc_reg, y_acc_next, x_acc_next};
                end
            end
            default:
            begin
            end
        endcase
    end

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = tdata_reg;
    assign cfg_ready     = 1'b1;

endmodule

[hdl/wgo_serial_mul.sv]
// Bit-serial unsigned shift-add multiplier, one multiplier bit per cycle.
module wgo_serial_mul #(
    parameter int A_W = 17,
    parameter int B_W = 28
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [A_W-1:0]     a,
    input  logic [B_W-1:0]     b,
    output logic               busy,
    output logic [A_W+B_W-1:0] product
);

    localparam int P_W   = A_W + B_W;
    localparam int CNT_W = $clog2(B_W);
    localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(B_W - 1);

    logic             busy_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [A_W-1:0]   a_reg;
    logic [P_W-1:0]   acc_reg;
    logic [A_W:0]     partial;
    logic [P_W-1:0]   acc_next;

    // upper half takes the multiplicand when the low bit is set, then all shifts right
    always_comb
    begin
        partial  = {1'b0, acc_reg[P_W-1:B_W]} + (acc_reg[0] ? {1'b0, a_reg} : '0);
        acc_next = {partial, acc_reg[B_W-1:1]};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start && !busy_reg)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg + 1'b1;
            if (cnt_reg == LAST_STEP)
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start && !busy_reg)
        begin
            a_reg   <= a;
            acc_reg <= {{A_W{1'b0}}, b};
        end
        else if (busy_reg)
        begin
            acc_reg <= acc_next;
        end
    end

    assign busy    = busy_reg;
    assign product = acc_reg;

endmodule

[hdl/wgo_cordic.sv]
// Iterative rotation-mode CORDIC giving Q30 cosine and sine of a binary angle.
module wgo_cordic #(
    parameter int ITERATIONS = 16
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    input  logic [wgo_pkg::ANGLE_W-1:0]          angle,
    output logic                                 busy,
    output logic signed [wgo_pkg::TRIG_W-1:0]    cos_out,
    output logic signed [wgo_pkg::TRIG_W-1:0]    sin_out
);

    import wgo_pkg::*;

    localparam logic [ATAN_IDX_W-1:0] LAST_ITER = ATAN_IDX_W'(ITERATIONS - 1);

    localparam logic [1:0] QUAD_ZERO  = 2'd0;
    localparam logic [1:0] QUAD_LEFT  = 2'd1;
    localparam logic [1:0] QUAD_BACK  = 2'd2;

    typedef enum logic [1:0] {
        CS_IDLE,
        CS_ROTATE,
        CS_FINISH
    } cordic_state_t;

    cordic_state_t              state_reg;
    logic [ATAN_IDX_W-1:0]      iter_reg;
    logic [1:0]                 quad_reg;
    logic signed [TRIG_W-1:0]   x_reg;
    logic signed [TRIG_W-1:0]   y_reg;
    logic [TRIG_W-1:0]          z_reg;
    logic signed [TRIG_W-1:0]   cos_reg;
    logic signed [TRIG_W-1:0]   sin_reg;

    logic [ANGLE_W-1:0]         biased;
    logic [1:0]                 quad_in;
    logic [ANGLE_W-1:0]         residue;
    logic signed [TRIG_W-1:0]   x_shift;
    logic signed [TRIG_W-1:0]   y_shift;
    logic [TRIG_W-1:0]          atan_val;
    logic signed [TRIG_W-1:0]   x_next;
    logic signed [TRIG_W-1:0]   y_next;
    logic [TRIG_W-1:0]          z_next;

    always_comb
    begin
        biased   = angle + EIGHTH_TURN;
        quad_in  = biased[ANGLE_W-1:ANGLE_W-2];
        residue  = angle - {quad_in, {(ANGLE_W-2){1'b0}}};
        x_shift  = x_reg >>> iter_reg;
        y_shift  = y_reg >>> iter_reg;
        atan_val = atan_turn(iter_reg);
        if (!z_reg[TRIG_W-1])
        begin
            x_next = x_reg - y_shift;
            y_next = y_reg + x_shift;
            z_next = z_reg - atan_val;
        end
        else
        begin
            x_next = x_reg + y_shift;
            y_next = y_reg - x_shift;
            z_next = z_reg + atan_val;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= CS_IDLE;
            iter_reg  <= '0;
        end
        else
        begin
            case (state_reg)
                CS_IDLE:
                begin
                    if (start)
                    begin
                        state_reg <= CS_ROTATE;
                        iter_reg  <= '0;
                    end
                end
                CS_ROTATE:
                begin
                    iter_reg <= iter_reg + 1'b1;
                    if (iter_reg == LAST_ITER)
                    begin
                        state_reg <= CS_FINISH;
                    end
                end
                CS_FINISH:
                begin
                    state_reg <= CS_IDLE;
                end
                default:
                begin
                    state_reg <= CS_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            CS_IDLE:
            begin
                if (start)
                begin
                    quad_reg <= quad_in;
                    x_reg    <= CORDIC_START;
                    y_reg    <= '0;
                    z_reg    <= {residue, {(TRIG_W-ANGLE_W){1'b0}}};
                end
            end
            CS_ROTATE:
            begin
                x_reg <= x_next;
                y_reg <= y_next;
                z_reg <= z_next;
            end
            CS_FINISH:
            begin
                case (quad_reg)
                    QUAD_ZERO:
                    begin
                        cos_reg <= x_reg;
                        sin_reg <= y_reg;
                    end
                    QUAD_LEFT:
                    begin
                        cos_reg <= -y_reg;
                        sin_reg <= x_reg;
                    end
                    QUAD_BACK:
                    begin
                        cos_reg <= -x_reg;
                        sin_reg <= -y_reg;
                    end
                    default:
                    begin
                        cos_reg <= y_reg;
                        sin_reg <= -x_reg;
                    end
                endcase
            end
            default:
            begin
            end
        endcase
    end

    assign busy    = (state_reg != CS_IDLE);
    assign cos_out = cos_reg;
    assign sin_out = sin_reg;

endmodule

[sim/wgo_odometry_checker.sv]
// Odometry checker: follows the stream and register transfers, predicts each pose and compares.
module wgo_odometry_checker #(
    parameter int TRIG_ITERATIONS = 16
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_axis_tvalid,
    input  logic                            s_axis_tready,
    // left_count, right_count, gyro_angle
    input  logic [wgo_pkg::S_TDATA_W-1:0]   s_axis_tdata,
    input  logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // pos_x, pos_y, heading, heading_step, step_distance, left_delta, right_delta, pad
    input  logic [wgo_pkg::M_TDATA_W-1:0]   m_axis_tdata,
    input  logic                            cfg_valid,
    input  logic                            cfg_ready,
    input  logic [wgo_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [wgo_pkg::CFG_DATA_W-1:0]  cfg_data,
    output int                              pending,
    output int                              fail_count
);
    timeunit 1ns;
    timeprecision 1ps;
    import wgo_pkg::*;

    localparam int OFF_Y    = POS_W;
    localparam int OFF_HEAD = 2 * POS_W;
    localparam int OFF_STEP = OFF_HEAD + ANGLE_W;
    localparam int OFF_DIST = OFF_STEP + ANGLE_W;
    localparam int OFF_LD   = OFF_DIST + DIST_W;
    localparam int OFF_RD   = OFF_LD + DELTA_W;

    localparam longint DIST_HI = (longint'(1) <<< (DIST_W - 1)) - 1;
    localparam longint DIST_LO = -(longint'(1) <<< (DIST_W - 1));
    localparam longint POS_HI  = longint'(POS_MAX);
    localparam longint POS_LO  = longint'(POS_MIN);

    typedef struct {
        logic signed [POS_W-1:0]   pos_x;
        logic signed [POS_W-1:0]   pos_y;
        logic signed [ANGLE_W-1:0] heading;
        logic signed [ANGLE_W-1:0] heading_step;
        logic signed [DIST_W-1:0]  step_distance;
        logic signed [DELTA_W-1:0] left_delta;
        logic signed [DELTA_W-1:0] right_delta;
    } pose_t;

    // atan(2^-i) in 2^-32 turn
    longint atan_tab [ATAN_DEPTH] = '{
        536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
        10679838, 5340245, 2670163, 1335087, 667544, 333772,
        166886, 83443, 41722, 20861, 10430, 5215,
        2608, 1304, 652, 326, 163, 81
    };

    pose_t              expected_poses[$];
    logic [MPP_W-1:0]   mpp = MPP_RESET;
    logic [WARM_W-1:0]  warm_limit = WARMUP_RESET;
    int                 warm_seen = 0;
    logic [COUNT_W-1:0] prev_left = '0;
    logic [COUNT_W-1:0] prev_right = '0;
    logic [ANGLE_W-1:0] prev_gyro = '0;
    logic [ANGLE_W-1:0] heading_acc = '0;
    longint             x_acc = 0;
    longint             y_acc = 0;

    function automatic int unwrap_count(input logic [COUNT_W-1:0] cur,
                                        input logic [COUNT_W-1:0] prev);
        int full;
        full = int'(FULL_COUNT);
        if (cur < QUARTER_COUNT && prev > THREE_QUARTER_COUNT)
            return int'(cur) + full - int'(prev);
        if (cur > THREE_QUARTER_COUNT && prev < QUARTER_COUNT)
            return int'(cur) - full - int'(prev);
        return int'(cur) - int'(prev);
    endfunction

    // divide by 2^sh, ties away from zero
    function automatic longint round_away(input longint v, input int sh);
        longint m;
        m = (v < 0) ? -v : v;
        m = (m + (longint'(1) <<< (sh - 1))) >>> sh;
        return (v < 0) ? -m : m;
    endfunction

    function automatic longint clamp(input longint v, input longint lo, input longint hi);
        if (v > hi)
            return hi;
        if (v < lo)
            return lo;
        return v;
    endfunction

    function automatic void heading_trig(input logic [ANGLE_W-1:0] ang,
                                         output longint cos_q, output longint sin_q);
        logic [ANGLE_W-1:0] shifted;
        logic [ANGLE_W-1:0] rem;
        logic [1:0]         quad;
        longint             x;
        longint             y;
        longint             z;
        longint             nx;
        shifted = ang + EIGHTH_TURN;
        quad = shifted[ANGLE_W-1 -: 2];
        rem = ang - {quad, 14'd0};
        x = longint'(CORDIC_START);
        y = 0;
        z = longint'($signed(rem)) <<< 16;
        for (int i = 0; i < TRIG_ITERATIONS && i < ATAN_DEPTH; i++)
        begin
            if (z >= 0)
            begin
                nx = x - (y >>> i);
                y = y + (x >>> i);
                z = z - atan_tab[i];
            end
            else
            begin
                nx = x + (y >>> i);
                y = y - (x >>> i);
                z = z + atan_tab[i];
            end
            x = nx;
        end
        case (quad)
            2'd0:
            begin
                cos_q = x;
                sin_q = y;
            end
            2'd1:
            begin
                cos_q = -y;
                sin_q = x;
            end
            2'd2:
            begin
                cos_q = -x;
                sin_q = -y;
            end
            default:
            begin
                cos_q = y;
                sin_q = -x;
            end
        endcase
    endfunction

    function automatic void advance_odometry(input logic [COUNT_W-1:0] l,
                                             input logic [COUNT_W-1:0] r,
                                             input logic [ANGLE_W-1:0] g);
        int                 ld;
        int                 rd;
        logic [ANGLE_W-1:0] turn;
        longint             travel;
        longint             cos_q;
        longint             sin_q;
        pose_t              p;
        if (warm_seen < int'(warm_limit))
        begin
            warm_seen++;
            prev_left = l;
            prev_right = r;
            prev_gyro = g;
            return;
        end
        ld = unwrap_count(l, prev_left);
        rd = unwrap_count(r, prev_right);
        turn = g - prev_gyro;
        heading_acc = heading_acc + turn;
        travel = clamp(round_away(longint'(ld + rd) * longint'(mpp), DIST_FRAC),
                       DIST_LO, DIST_HI);
        heading_trig(heading_acc, cos_q, sin_q);
        x_acc = clamp(x_acc + round_away(travel * cos_q, TRIG_FRAC), POS_LO, POS_HI);
        y_acc = clamp(y_acc + round_away(travel * sin_q, TRIG_FRAC), POS_LO, POS_HI);
        prev_left = l;
        prev_right = r;
        prev_gyro = g;
        p.pos_x = POS_W'(x_acc);
        p.pos_y = POS_W'(y_acc);
        p.heading = heading_acc;
        p.heading_step = turn;
        p.step_distance = DIST_W'(travel);
        p.left_delta = DELTA_W'(ld);
        p.right_delta = DELTA_W'(rd);
        expected_poses.push_back(p);
    endfunction

    function automatic void check_field(input string name, input logic signed [63:0] want,
                                        input logic signed [63:0] got);
        if (got !== want)
        begin
            $error("%s expected %0d got %0d", name, want, got);
            fail_count++;
        end
    endfunction

    function automatic void compare_pose();
        pose_t want;
        if (expected_poses.size() == 0)
        begin
            $error("pose transfer with no tick outstanding");
            fail_count++;
            return;
        end
        want = expected_poses.pop_front();
        check_field("pos_x", want.pos_x, $signed(m_axis_tdata[0 +: POS_W]));
        check_field("pos_y", want.pos_y, $signed(m_axis_tdata[OFF_Y +: POS_W]));
        check_field("heading", want.heading, $signed(m_axis_tdata[OFF_HEAD +: ANGLE_W]));
        check_field("heading_step", want.heading_step,
                    $signed(m_axis_tdata[OFF_STEP +: ANGLE_W]));
        check_field("step_distance", want.step_distance,
                    $signed(m_axis_tdata[OFF_DIST +: DIST_W]));
        check_field("left_delta", want.left_delta, $signed(m_axis_tdata[OFF_LD +: DELTA_W]));
        check_field("right_delta", want.right_delta, $signed(m_axis_tdata[OFF_RD +: DELTA_W]));
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mpp = MPP_RESET;
            warm_limit = WARMUP_RESET;
            warm_seen = 0;
            prev_left = '0;
            prev_right = '0;
            prev_gyro = '0;
            heading_acc = '0;
            x_acc = 0;
            y_acc = 0;
            expected_poses.delete();
            fail_count = 0;
            pending <= 0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
                compare_pose();
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == REG_METRES_PER_PULSE)
                    mpp = cfg_data[MPP_W-1:0];
                else if (cfg_index == REG_WARMUP_TICKS)
                    warm_limit = cfg_data[WARM_W-1:0];
            end
            if (s_axis_tvalid && s_axis_tready)
                advance_odometry(s_axis_tdata[0 +: COUNT_W], s_axis_tdata[COUNT_W +: COUNT_W],
                                 s_axis_tdata[2*COUNT_W +: ANGLE_W]);
            pending <= expected_poses.size();
        end
    end

endmodule

[sim/wheel_gyro_odometry_core_tb.sv]
// Testbench top for the odometry core: drives ticks and register writes, gives the verdict.
module wheel_gyro_odometry_core_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import wgo_pkg::*;

    localparam int TRIG_ITER      = 16;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int SETTLE_CYCLES  = 100;
    localparam int HOLD_AT        = 240;
    localparam int HOLD_CYCLES    = 600;
    localparam logic [MPP_W-1:0] MPP_FULL = {MPP_W{1'b1}};

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [S_TDATA_W-1:0]  s_axis_tdata = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0]  m_axis_tdata;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    int                    pending;
    int                    fail_count;
    int                    send_idle_pct = 0;
    int                    recv_idle_pct = 0;
    int                    warm_seen = 0;
    int                    warm_limit = int'(WARMUP_RESET);
    logic [COUNT_W-1:0]    cur_left = '0;
    logic [COUNT_W-1:0]    cur_right = '0;
    logic [ANGLE_W-1:0]    cur_gyro = '0;
    int                    inputs_seen = 0;
    int                    hold_left = 0;
    bit                    hold_done = 1'b0;
    int                    quiet_cycles = 0;

    wheel_gyro_odometry_core #(
        .TRIG_ITERATIONS(TRIG_ITER)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    wgo_odometry_checker #(
        .TRIG_ITERATIONS(TRIG_ITER)
    ) u_checker (
        .clk(clk),
        .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .pending(pending),
        .fail_count(fail_count)
    );

    always #5 clk = ~clk;

    // pose receiver, with one long hold-off once the input has seen HOLD_AT transfers
    always @(posedge clk)
    begin
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
                inputs_seen++;
            if (!hold_done && inputs_seen >= HOLD_AT)
            begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end
            else
                m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
            || (cfg_valid && cfg_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("wheel_gyro_odometry_core verification failed");
            $finish;
        end
    end

    task automatic send_tick(input logic [COUNT_W-1:0] l, input logic [COUNT_W-1:0] r,
                             input logic [ANGLE_W-1:0] g);
        while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {g, r, l};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        cur_left = l;
        cur_right = r;
        cur_gyro = g;
        if (warm_seen < warm_limit)
            warm_seen++;
    endtask

    task automatic drain_poses();
        s_axis_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (pending != 0);
        repeat (SETTLE_CYCLES)
            @(posedge clk);
    endtask

    task automatic set_registers(input logic [MPP_W-1:0] mpp, input logic [WARM_W-1:0] warm);
        cfg_valid <= 1'b1;
        cfg_index <= REG_METRES_PER_PULSE;
        cfg_data <= mpp;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_index <= REG_WARMUP_TICKS;
        cfg_data <= CFG_DATA_W'(warm);
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        warm_limit = int'(warm);
    endtask

    // mostly plausible motion with steps of varied size, some with a half turn, the rest raw noise
    task automatic random_ticks(input int n);
        int kind;
        int span;
        logic [COUNT_W-1:0] l;
        logic [COUNT_W-1:0] r;
        logic [ANGLE_W-1:0] g;
        repeat (n)
        begin
            kind = $urandom_range(99);
            if (kind < 80)
            begin
                span = (kind < 40) ? 64 : (kind < 70) ? 4096 : 16383;
                l = cur_left + COUNT_W'(int'($urandom_range(2 * span)) - span);
                r = cur_right + COUNT_W'(int'($urandom_range(2 * span)) - span);
                if (kind < 75)
                    g = cur_gyro + ANGLE_W'(int'($urandom_range(1024)) - 512);
                else
                    g = cur_gyro + 16'h8000;
            end
            else
            begin
                l = COUNT_W'($urandom);
                r = COUNT_W'($urandom);
                g = ANGLE_W'($urandom);
            end
            send_tick(l, r, g);
        end
    endtask

    initial
    begin
        repeat (3)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_idle_pct = 35;
        recv_idle_pct = 68;
        repeat (int'(WARMUP_RESET))
            send_tick(COUNT_W'($urandom), COUNT_W'($urandom), ANGLE_W'($urandom));

        // encoder wrap both ways, quarter boundaries, half-turn gyro change
        send_tick(16'd0, 16'd0, 16'h0000);
        send_tick(16'd16383, 16'd49153, 16'h4000);
        send_tick(16'd65535, 16'd0, 16'hC000);
        send_tick(16'd16384, 16'd49152, 16'h8000);
        send_tick(16'd49153, 16'd16383, 16'h7FFF);
        send_tick(16'd0, 16'd65535, 16'hFFFF);
        send_tick(16'd65535, 16'd65535, 16'h8000);
        send_tick(16'd16383, 16'd16383, 16'h0000);
        send_tick(16'd16383, 16'd16383, 16'h0001);
        send_tick(16'h5555, 16'hAAAA, 16'h2000);
        drain_poses();

        // travel saturation both ways
        set_registers(MPP_FULL, WARMUP_RESET);
        send_tick(16'd0, 16'd0, 16'h0000);
        send_tick(16'd49152, 16'd49152, 16'h6000);
        send_tick(16'd0, 16'd0, 16'hA000);
        send_tick(16'h1000, 16'h1000, 16'hE000);
        drain_poses();

        set_registers('0, WARMUP_RESET);
        send_tick(16'd1234, 16'd4321, 16'h1234);
        send_tick(16'hFFFF, 16'h0000, 16'h9000);
        drain_poses();

        // warm-up resumes for a few ticks
        set_registers(MPP_RESET, WARM_W'(warm_seen + 5));
        random_ticks(350);
        drain_poses();

        send_idle_pct = 68;
        recv_idle_pct = 35;
        set_registers(MPP_W'($urandom), WARM_W'(warm_limit));
        random_ticks(300);
        drain_poses();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        set_registers(MPP_W'($urandom_range(1 << 24)), WARM_W'(warm_seen + 40));
        while (warm_seen < warm_limit)
            send_tick(COUNT_W'($urandom), COUNT_W'($urandom), ANGLE_W'($urandom));
        random_ticks(300);
        drain_poses();

        set_registers(MPP_W'($urandom), '0);
        random_ticks(50);
        drain_poses();

        if (fail_count == 0)
            $display("wheel_gyro_odometry_core verification clean");
        else
            $display("wheel_gyro_odometry_core verification failed");
        $finish;
    end

endmodule

[wheel_gyro_odometry_core.f]
hdl/wgo_pkg.sv
hdl/wgo_serial_mul.sv
hdl/wgo_cordic.sv
hdl/wheel_gyro_odometry_core.sv
sim/wgo_odometry_checker.sv
sim/wheel_gyro_odometry_core_tb.sv
